// File: sv/sspg_pkg.sv
// Shared types and constants for the step/direction pulse generator.
`timescale 1ns / 1ps

package sspg_pkg;

    // Fixed field widths
    localparam int FREQ_W    = 20;
    localparam int RATE_W    = 16;
    localparam int INC_W     = 17;
    localparam int POS_W     = 32;
    localparam int CNT_IN_W  = 32;
    localparam int PROD_W    = CNT_IN_W + FREQ_W;   // |wait| * frequency
    localparam int DIV_CNT_W = $clog2(PROD_W);
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Reset values of the settings and the rate
    localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd100000;
    localparam logic [INC_W-1:0]  INC_RESET  = 17'd20000;

    // Register indexes (paddr[2])
    localparam logic REG_FREQ  = 1'b0;
    localparam logic REG_MICRO = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_GOTO  = 2'd2,
        OP_PAUSE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_DIR_ASSERT = 2'd1,
        MODE_STEPPING   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DIR_FORWARDS  = 2'd0,
        DIR_BACKWARDS = 2'd1,
        DIR_PAUSED    = 2'd2
    } dir_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_DIV  = 1'b1
    } ctl_state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [CNT_IN_W-1:0] count;
        logic [RATE_W-1:0]         rate;
    } req_item_t;

    typedef struct packed {
        logic                    step_out;
        logic                    dir_out;
        logic                    microstep_out;
        logic                    busy_res;
        logic signed [POS_W-1:0] position;
        logic                    done_res;
    } rsp_item_t;

    // Controller to datapath
    typedef struct packed {
        logic take;       // request accepted this cycle
        logic div_step;   // one quotient bit
        logic div_last;   // final quotient bit, load step budget
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pause_req;  // pending request is a timed pause
    } ctl_sts_t;

endpackage

// File: sv/sspg_ctrl.sv
// Controller: request/response handshake and pause divider sequencing.
`timescale 1ns / 1ps

module sspg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  sspg_pkg::ctl_sts_t  sts,
    output sspg_pkg::ctl_cmd_t  cmd
);

    sspg_pkg::ctl_state_t state_reg, state_next;
    logic [sspg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic take;
    logic last;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sspg_pkg::CS_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Accept only when idle and the response slot frees up
    assign req_stall = (state_reg != sspg_pkg::CS_IDLE) || (rsp_valid_reg && rsp_stall);
    assign take      = req_valid && !req_stall;
    assign last      = (cnt_reg == sspg_pkg::DIV_CNT_W'(sspg_pkg::PROD_W - 1));
    assign rsp_valid = rsp_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.take     = take;
        cmd.div_step = 1'b0;
        cmd.div_last = 1'b0;

        if (take)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;

        case (state_reg)
            sspg_pkg::CS_IDLE:
            begin
                cnt_next = '0;
                if (take && sts.pause_req)
                    state_next = sspg_pkg::CS_DIV;
            end
            sspg_pkg::CS_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = last;
                cnt_next     = cnt_reg + 1'b1;
                if (last)
                    state_next = sspg_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = sspg_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sspg_datapath.sv
// Datapath: motion state, rate accumulator, pause divider, settings and response register.
`timescale 1ns / 1ps

module sspg_datapath
#(
    parameter int COUNT_WIDTH = 32,
    parameter int ACC_WIDTH   = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sspg_pkg::req_item_t               req,
    output sspg_pkg::rsp_item_t               rsp,
    input  sspg_pkg::ctl_cmd_t                cmd,
    output sspg_pkg::ctl_sts_t                sts,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sspg_pkg::PADDR_W-1:0]      paddr,
    input  logic [sspg_pkg::PDATA_W-1:0]      pwdata,
    output logic [sspg_pkg::PDATA_W-1:0]      prdata
);

    localparam int BIG_W = (COUNT_WIDTH > sspg_pkg::PROD_W) ? COUNT_WIDTH : sspg_pkg::PROD_W;
    localparam int CMP_W = (ACC_WIDTH > sspg_pkg::FREQ_W) ? ACC_WIDTH : sspg_pkg::FREQ_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONES = '1;
    localparam logic [ACC_WIDTH-1:0]   ACC_ONES = '1;

    // Settings
    logic [sspg_pkg::FREQ_W-1:0] freq_reg;
    logic                        micro_reg;

    // Motion state
    sspg_pkg::mode_t             mode_reg, mode_next;
    sspg_pkg::dir_t              dir_reg, dir_next;
    logic [COUNT_WIDTH-1:0]      steps_reg, steps_next;
    logic [sspg_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [ACC_WIDTH-1:0]        acc_reg, acc_next;
    logic [sspg_pkg::INC_W-1:0]  inc_reg, inc_next;
    logic                        step_reg, step_next;
    logic                        dirpin_reg, dirpin_next;
    logic                        done_next;

    // Pause divider
    logic [sspg_pkg::PROD_W-1:0] quo_reg, quo_next;
    logic [sspg_pkg::RATE_W-1:0] rem_reg, rem_next;
    logic [sspg_pkg::RATE_W:0]   trial;
    logic [sspg_pkg::RATE_W:0]   trial_sub;
    logic                        trial_ge;
    logic                        div_zero;
    logic [sspg_pkg::PROD_W-1:0] prod;
    logic [BIG_W-1:0]            quo_wide;
    logic [COUNT_WIDTH-1:0]      quo_sat;

    // Response register
    sspg_pkg::rsp_item_t         rsp_reg, rsp_next;

    // Request decode
    logic [sspg_pkg::CNT_IN_W-1:0] cnt_u;
    logic [sspg_pkg::CNT_IN_W-1:0] cnt_mag;
    logic [sspg_pkg::CNT_IN_W:0]   diff;
    logic [sspg_pkg::CNT_IN_W:0]   diff_mag;
    logic [BIG_W-1:0]              budget_wide;
    logic [COUNT_WIDTH-1:0]        budget_sat;

    // Accumulator arithmetic
    logic [ACC_WIDTH:0]            acc_sum;
    logic [ACC_WIDTH-1:0]          acc_sat;
    logic [CMP_W-1:0]              acc_cmp;
    logic [CMP_W-1:0]              freq_cmp;
    logic [CMP_W-1:0]              acc_red;

    logic                          wr_en;

    assign sts.pause_req = (req.op == sspg_pkg::OP_PAUSE);
    assign rsp           = rsp_reg;

    // Magnitudes of the move count and of the goto distance
    assign cnt_u    = req.count;
    assign cnt_mag  = cnt_u[sspg_pkg::CNT_IN_W-1] ? (32'd0 - cnt_u) : cnt_u;
    assign diff     = {cnt_u[sspg_pkg::CNT_IN_W-1], cnt_u}
                    - {pos_reg[sspg_pkg::POS_W-1], pos_reg};
    assign diff_mag = diff[sspg_pkg::CNT_IN_W] ? (33'd0 - diff) : diff;

    // Step budget saturates to the counter width
    assign budget_wide = (req.op == sspg_pkg::OP_GOTO) ? BIG_W'(diff_mag) : BIG_W'(cnt_mag);
    assign budget_sat  = (budget_wide > BIG_W'(CNT_ONES)) ? CNT_ONES
                                                          : budget_wide[COUNT_WIDTH-1:0];

    // Pause dividend: |wait| * frequency
    assign prod = cnt_mag * freq_reg;

    // Restoring divider, one quotient bit per cycle; divisor is the stored rate.
    // A zero divisor forces the budget to all ones of the counter width.
    assign trial     = {rem_reg, quo_reg[sspg_pkg::PROD_W-1]};
    assign trial_ge  = (trial >= {1'b0, inc_reg[sspg_pkg::RATE_W-1:0]});
    assign trial_sub = trial - {1'b0, inc_reg[sspg_pkg::RATE_W-1:0]};
    assign rem_next  = trial_ge ? trial_sub[sspg_pkg::RATE_W-1:0] : trial[sspg_pkg::RATE_W-1:0];
    assign quo_next  = {quo_reg[sspg_pkg::PROD_W-2:0], trial_ge};
    assign quo_wide  = BIG_W'(quo_next);
    assign div_zero  = (inc_reg[sspg_pkg::RATE_W-1:0] == '0);
    assign quo_sat   = (div_zero || (quo_wide > BIG_W'(CNT_ONES))) ? CNT_ONES
                                                                   : quo_wide[COUNT_WIDTH-1:0];

    // Saturating accumulator and threshold compare
    assign acc_sum  = {1'b0, acc_reg} + (ACC_WIDTH + 1)'(inc_reg);
    assign acc_sat  = acc_sum[ACC_WIDTH] ? ACC_ONES : acc_sum[ACC_WIDTH-1:0];
    assign acc_cmp  = CMP_W'(acc_sat);
    assign freq_cmp = CMP_W'(freq_reg);
    assign acc_red  = acc_cmp - freq_cmp;

    // Next motion state for the pending request
    always_comb
    begin
        mode_next   = mode_reg;
        dir_next    = dir_reg;
        steps_next  = steps_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        inc_next    = inc_reg;
        step_next   = step_reg;
        dirpin_next = dirpin_reg;
        done_next   = 1'b0;

        case (req.op)
            sspg_pkg::OP_MOVE, sspg_pkg::OP_GOTO:
            begin
                if (req.op == sspg_pkg::OP_MOVE)
                    dir_next = cnt_u[sspg_pkg::CNT_IN_W-1] ? sspg_pkg::DIR_BACKWARDS
                                                           : sspg_pkg::DIR_FORWARDS;
                else
                    dir_next = diff[sspg_pkg::CNT_IN_W] ? sspg_pkg::DIR_BACKWARDS
                                                        : sspg_pkg::DIR_FORWARDS;
                step_next  = 1'b0;
                steps_next = budget_sat;
                acc_next   = '0;
                inc_next   = {1'b0, req.rate};
                mode_next  = sspg_pkg::MODE_DIR_ASSERT;
            end
            sspg_pkg::OP_PAUSE:
            begin
                // Budget is loaded when the divider finishes
                dir_next    = sspg_pkg::DIR_PAUSED;
                dirpin_next = 1'b0;
                acc_next    = '0;
                inc_next    = {1'b0, req.rate};
                mode_next   = sspg_pkg::MODE_STEPPING;
            end
            default:
            begin
                case (mode_reg)
                    sspg_pkg::MODE_DIR_ASSERT:
                    begin
                        dirpin_next = (dir_reg == sspg_pkg::DIR_FORWARDS);
                        mode_next   = sspg_pkg::MODE_STEPPING;
                    end
                    sspg_pkg::MODE_STEPPING:
                    begin
                        if (steps_reg == '0)
                        begin
                            mode_next = sspg_pkg::MODE_IDLE;
                            step_next = 1'b0;
                            done_next = 1'b1;
                        end
                        else if (dir_reg == sspg_pkg::DIR_PAUSED)
                        begin
                            steps_next = steps_reg - 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_sat;
                            if (step_reg)
                            begin
                                step_next = 1'b0;
                            end
                            else if (acc_cmp >= freq_cmp)
                            begin
                                acc_next   = acc_red[ACC_WIDTH-1:0];
                                step_next  = 1'b1;
                                steps_next = steps_reg - 1'b1;
                                if (dir_reg == sspg_pkg::DIR_FORWARDS)
                                    pos_next = pos_reg + 1'b1;
                                else
                                    pos_next = pos_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        endcase
    end

    // Response fields after the request
    always_comb
    begin
        rsp_next.step_out      = step_next;
        rsp_next.dir_out       = dirpin_next;
        rsp_next.microstep_out = micro_reg;
        rsp_next.busy_res      = (mode_next != sspg_pkg::MODE_IDLE);
        rsp_next.position      = pos_next;
        rsp_next.done_res      = done_next;
    end

    // Settings write and read
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == sspg_pkg::REG_MICRO) ? sspg_pkg::PDATA_W'(micro_reg)
                                                      : sspg_pkg::PDATA_W'(freq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg  <= sspg_pkg::FREQ_RESET;
            micro_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            if (paddr[2] == sspg_pkg::REG_FREQ)
                freq_reg <= pwdata[sspg_pkg::FREQ_W-1:0];
            else
                micro_reg <= pwdata[0];
        end
    end

    // Motion state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sspg_pkg::MODE_IDLE;
            dir_reg    <= sspg_pkg::DIR_FORWARDS;
            steps_reg  <= '0;
            pos_reg    <= '0;
            acc_reg    <= '0;
            inc_reg    <= sspg_pkg::INC_RESET;
            step_reg   <= 1'b0;
            dirpin_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            mode_reg   <= mode_next;
            dir_reg    <= dir_next;
            steps_reg  <= steps_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            inc_reg    <= inc_next;
            step_reg   <= step_next;
            dirpin_reg <= dirpin_next;
        end
        else if (cmd.div_last)
        begin
            steps_reg <= quo_sat;
        end
    end

    // Divider and response payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            quo_reg <= prod;
            rem_reg <= '0;
            rsp_reg <= rsp_next;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// File: sv/stepper_step_pulse_generator_unit.sv
// Top level of the step/direction pulse generator.
// A response is registered and appears in the cycle after its request is accepted.
// Ticks, moves and gotos are accepted back to back unless the response is stalled;
// a timed pause holds req_stall while the restoring divider produces one bit
// of |wait|*frequency/precision per cycle.
// Reset: rst_n clears motion state, loads frequency 100000 and microstep 1.
`timescale 1ns / 1ps

module stepper_step_pulse_generator_unit
#(
    parameter int COUNT_WIDTH = 32,
    parameter int ACC_WIDTH   = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sspg_pkg::req_item_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sspg_pkg::rsp_item_t           rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sspg_pkg::PADDR_W-1:0]  paddr,
    input  logic [sspg_pkg::PDATA_W-1:0]  pwdata,
    output logic [sspg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    sspg_pkg::ctl_cmd_t cmd;
    sspg_pkg::ctl_sts_t sts;

    assign pready = 1'b1;

    // Sequencer
    sspg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Motion datapath
    sspg_datapath
    #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .cmd     (cmd),
        .sts     (sts),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

endmodule

// File: sv/sspg_checker.sv
// Port-level checks for the pulse generator, bound to the top level.
`timescale 1ns / 1ps

module sspg_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input sspg_pkg::rsp_item_t rsp,
    input logic                rsp_valid,
    input logic                rsp_stall
);

    // A stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // Every accepted request gives a response in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("request without response");

    // Done only on the return to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.done_res |-> !rsp.busy_res)
        else $error("done while busy");

    // Step pin is low whenever the generator is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.busy_res |-> !rsp.step_out)
        else $error("step high while idle");

endmodule

bind stepper_step_pulse_generator_unit sspg_checker u_sspg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
);

// File: tb/tb_stepper_step_pulse_generator_unit.sv
// Testbench for the step/direction pulse generator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_stepper_step_pulse_generator_unit;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 221;
    localparam int PHASE_COUNT  = 6;
    localparam int TICK_CAP     = 260;

    // One row of the opening table; rsp is used only when typed is set
    typedef struct packed {
        sspg_pkg::op_t       op;
        logic [31:0]         count;
        logic [15:0]         rate;
        logic                typed;
        sspg_pkg::rsp_item_t rsp;
    } table_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    sspg_pkg::req_item_t            req;
    logic                           rsp_valid;
    logic                           rsp_stall;
    sspg_pkg::rsp_item_t            rsp;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sspg_pkg::PADDR_W-1:0]   paddr;
    logic [sspg_pkg::PDATA_W-1:0]   pwdata;
    logic [sspg_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Motion model state and its copy of the settings
    sspg_pkg::mode_t                motion_mode;
    sspg_pkg::dir_t                 motion_dir;
    logic [31:0]                    steps_remaining;
    logic signed [31:0]             pos_count;
    logic [31:0]                    rate_acc;
    logic [sspg_pkg::INC_W-1:0]     rate_inc;
    logic                           step_pin;
    logic                           dir_pin;
    logic [sspg_pkg::FREQ_W-1:0]    cfg_freq;
    logic                           cfg_micro;

    sspg_pkg::rsp_item_t   pin_forecast[$];
    int                    mismatches;
    int                    requests_sent;
    int                    pulse_total;
    int                    pause_total;
    int                    done_total;
    bit                    hold_start;
    bit                    steady_flow;

    table_row_t opening_rows [24] = '{
        '{sspg_pkg::OP_TICK,  32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 32'sd0, 1'b0}},
        '{sspg_pkg::OP_MOVE,  32'd3,         16'hFFFF, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b1, 32'sd0, 1'b0}},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b1,
          '{1'b0, 1'b1, 1'b1, 1'b1, 32'sd0, 1'b0}},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        // pause arrives while the step pin is high
        '{sspg_pkg::OP_PAUSE, 32'd2,         16'hFFFF, 1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        // most negative step count
        '{sspg_pkg::OP_MOVE,  32'h8000_0000, 16'hFFFF, 1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        // far goto from position zero
        '{sspg_pkg::OP_GOTO,  32'h7FFF_FFFF, 16'd1,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        // zero precision, then an oversized pause
        '{sspg_pkg::OP_PAUSE, 32'd5,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_PAUSE, 32'h8000_0000, 16'd1,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        // empty move finishes right after the direction phase
        '{sspg_pkg::OP_MOVE,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_TICK,  32'd0,         16'd0,    1'b0, '0},
        '{sspg_pkg::OP_GOTO,  32'hFFFF_FFFB, 16'hFFFF, 1'b0, '0}
    };

    stepper_step_pulse_generator_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(30_000_000);
        $display("simulation failed");
        $finish;
    end

    // New move or goto: clear the pins' pacing and enter the direction phase
    function automatic void load_motion(input sspg_pkg::dir_t d, input logic [63:0] budget,
                                        input logic [15:0] rate);
        motion_dir      = d;
        step_pin        = 1'b0;
        steps_remaining = (budget > 64'hFFFF_FFFF) ? '1 : budget[31:0];
        rate_acc        = '0;
        rate_inc        = {1'b0, rate};
        motion_mode     = sspg_pkg::MODE_DIR_ASSERT;
    endfunction

    // Applies one request to the motion model and returns the pin state it leaves
    function automatic sspg_pkg::rsp_item_t advance_motion(input sspg_pkg::req_item_t r);
        logic signed [63:0]  cnt;
        logic signed [63:0]  here;
        logic signed [63:0]  diff;
        logic [63:0]         mag;
        logic [63:0]         sum;
        logic [63:0]         budget;
        logic                done;
        sspg_pkg::rsp_item_t res;
        cnt  = r.count;
        here = pos_count;
        done = 1'b0;
        case (r.op)
            sspg_pkg::OP_MOVE:
            begin
                mag = (cnt < 0) ? -cnt : cnt;
                load_motion((cnt >= 0) ? sspg_pkg::DIR_FORWARDS : sspg_pkg::DIR_BACKWARDS,
                            mag, r.rate);
            end
            sspg_pkg::OP_GOTO:
            begin
                diff = cnt - here;
                mag  = (diff < 0) ? -diff : diff;
                load_motion((here <= cnt) ? sspg_pkg::DIR_FORWARDS : sspg_pkg::DIR_BACKWARDS,
                            mag, r.rate);
            end
            sspg_pkg::OP_PAUSE:
            begin
                mag         = (cnt < 0) ? -cnt : cnt;
                motion_dir  = sspg_pkg::DIR_PAUSED;
                dir_pin     = 1'b0;
                rate_acc    = '0;
                rate_inc    = {1'b0, r.rate};
                pause_total++;
                if (r.rate == '0)
                    steps_remaining = '1;
                else
                begin
                    budget = (mag * 64'(cfg_freq)) / 64'(r.rate);
                    steps_remaining = (budget > 64'hFFFF_FFFF) ? '1 : budget[31:0];
                end
                motion_mode = sspg_pkg::MODE_STEPPING;
            end
            default:
            begin
                if (motion_mode == sspg_pkg::MODE_DIR_ASSERT)
                begin
                    dir_pin     = (motion_dir == sspg_pkg::DIR_FORWARDS);
                    motion_mode = sspg_pkg::MODE_STEPPING;
                end
                else if (motion_mode == sspg_pkg::MODE_STEPPING)
                begin
                    if (steps_remaining == '0)
                    begin
                        motion_mode = sspg_pkg::MODE_IDLE;
                        step_pin    = 1'b0;
                        done        = 1'b1;
                        done_total++;
                    end
                    else if (motion_dir == sspg_pkg::DIR_PAUSED)
                        steps_remaining--;
                    else
                    begin
                        // saturating phase accumulator
                        sum      = 64'(rate_acc) + 64'(rate_inc);
                        rate_acc = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
                        if (step_pin)
                            step_pin = 1'b0;
                        else if (rate_acc >= 32'(cfg_freq))
                        begin
                            rate_acc = rate_acc - 32'(cfg_freq);
                            step_pin = 1'b1;
                            steps_remaining--;
                            pulse_total++;
                            if (motion_dir == sspg_pkg::DIR_FORWARDS)
                                pos_count = pos_count + 32'sd1;
                            else
                                pos_count = pos_count - 32'sd1;
                        end
                    end
                end
            end
        endcase
        res.step_out      = step_pin;
        res.dir_out       = dir_pin;
        res.microstep_out = cfg_micro;
        res.busy_res      = (motion_mode != sspg_pkg::MODE_IDLE);
        res.position      = pos_count;
        res.done_res      = done;
        return res;
    endfunction

    function automatic sspg_pkg::req_item_t make_req(input sspg_pkg::op_t op,
                                                     input logic [31:0] count,
                                                     input logic [15:0] rate);
        sspg_pkg::req_item_t r;
        r.op    = op;
        r.count = count;
        r.rate  = rate;
        return r;
    endfunction

    // Sender gap: mostly none, some short, a few long
    function automatic int idle_gap();
        int pick;
        if (steady_flow)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Rate fast enough that a step takes at most about 17 ticks
    function automatic logic [15:0] quick_rate();
        int lo;
        lo = cfg_freq / 16;
        if (lo < 1)
            lo = 1;
        return 16'($urandom_range(lo, 65535));
    endfunction

    // Offer one request, hold it until taken, then log what it should produce
    task automatic send(input sspg_pkg::req_item_t item, input bit typed,
                        input sspg_pkg::rsp_item_t typed_rsp);
        int                  gap;
        sspg_pkg::rsp_item_t predicted;
        gap = idle_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = advance_motion(item);
        pin_forecast.push_back(typed ? typed_rsp : predicted);
        requests_sent++;
    endtask

    task automatic send_tick();
        send(make_req(sspg_pkg::OP_TICK, $urandom, 16'($urandom_range(0, 65535))), 1'b0, '0);
    endtask

    // Either a few ticks that may cut the command short, or ticks until idle
    task automatic tick_run(input bit to_idle);
        int n;
        int limit;
        limit = to_idle ? TICK_CAP : $urandom_range(0, 10);
        n = 0;
        while (n < limit && !(to_idle && motion_mode == sspg_pkg::MODE_IDLE))
        begin
            send_tick();
            n++;
        end
    endtask

    // Stop offering and let every outstanding response come back
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pin_forecast.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Register write followed by a read back
    task automatic set_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == sspg_pkg::REG_FREQ)
            cfg_freq = value[sspg_pkg::FREQ_W-1:0];
        else
            cfg_micro = value[0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((idx == sspg_pkg::REG_FREQ && prdata[sspg_pkg::FREQ_W-1:0] !== cfg_freq) ||
            (idx == sspg_pkg::REG_MICRO && prdata[0] !== cfg_micro))
        begin
            $error("register %0d read back: expected %0h, got %0h", idx,
                   (idx == sspg_pkg::REG_FREQ) ? 32'(cfg_freq) : 32'(cfg_micro), prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: runs of stall and free cycles, plus one long hold on request
    initial
    begin : rsp_side
        int run_left;
        bit run_val;
        int pick;
        rsp_stall = 1'b0;
        run_left  = 0;
        run_val   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                run_val    = 1'b1;
                run_left   = HOLD_CYCLES;
            end
            else if (run_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (steady_flow || pick < 50)
                begin
                    run_val  = 1'b0;
                    run_left = $urandom_range(1, 8);
                end
                else if (pick < 92)
                begin
                    run_val  = 1'b1;
                    run_left = $urandom_range(1, 3);
                end
                else
                begin
                    run_val  = 1'b1;
                    run_left = $urandom_range(10, 40);
                end
            end
            run_left--;
            rsp_stall <= run_val;
        end
    end

    // Response check against the oldest forecast
    initial
    begin : rsp_check
        sspg_pkg::rsp_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pin_forecast.size() == 0)
                begin
                    $error("response with nothing outstanding: %p", rsp);
                    mismatches++;
                end
                else
                begin
                    want = pin_forecast.pop_front();
                    if (rsp.step_out !== want.step_out)
                    begin
                        $error("step_out: expected %0d, got %0d", want.step_out, rsp.step_out);
                        mismatches++;
                    end
                    if (rsp.dir_out !== want.dir_out)
                    begin
                        $error("dir_out: expected %0d, got %0d", want.dir_out, rsp.dir_out);
                        mismatches++;
                    end
                    if (rsp.microstep_out !== want.microstep_out)
                    begin
                        $error("microstep_out: expected %0d, got %0d",
                               want.microstep_out, rsp.microstep_out);
                        mismatches++;
                    end
                    if (rsp.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy_res, rsp.busy_res);
                        mismatches++;
                    end
                    if (rsp.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, rsp.position);
                        mismatches++;
                    end
                    if (rsp.done_res !== want.done_res)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done_res, rsp.done_res);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stim
        int          pick;
        int          delta;
        int          phase_end;
        int          lo;
        logic [15:0] prec;
        logic [19:0] freq;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        mismatches    = 0;
        requests_sent = 0;
        pulse_total   = 0;
        pause_total   = 0;
        done_total    = 0;
        hold_start    = 1'b0;
        steady_flow   = 1'b0;

        motion_mode     = sspg_pkg::MODE_IDLE;
        motion_dir      = sspg_pkg::DIR_FORWARDS;
        steps_remaining = '0;
        pos_count       = '0;
        rate_acc        = '0;
        rate_inc        = sspg_pkg::INC_RESET;
        step_pin        = 1'b0;
        dir_pin         = 1'b0;
        cfg_freq        = sspg_pkg::FREQ_RESET;
        cfg_micro       = 1'b1;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Opening table at the reset settings
        foreach (opening_rows[i])
            send(make_req(opening_rows[i].op, opening_rows[i].count, opening_rows[i].rate),
                 opening_rows[i].typed, opening_rows[i].rsp);

        // Random phases, each under its own settings
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            case (p)
                0: freq = 20'd1;
                1: freq = 20'd1000000;
                2: freq = 20'd0;
                3: freq = 20'hFFFFF;
                default: freq = $urandom_range(0, 1) ? 20'($urandom_range(1, 1000000))
                                                     : 20'($urandom_range(1, 2000));
            endcase
            set_reg(sspg_pkg::REG_FREQ, 32'(freq));
            set_reg(sspg_pkg::REG_MICRO, (p < 4) ? 32'(p % 2) : 32'($urandom_range(0, 1)));
            steady_flow = (p == 3);
            if (p == 1)
                hold_start = 1'b1;
            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    delta = $urandom_range(0, 16);
                    delta -= 8;
                    send(make_req(sspg_pkg::OP_MOVE, delta, quick_rate()), 1'b0, '0);
                    tick_run($urandom_range(0, 9) < 7);
                end
                else if (pick < 55)
                begin
                    delta = $urandom_range(0, 16);
                    delta -= 8;
                    send(make_req(sspg_pkg::OP_GOTO, pos_count + delta, quick_rate()),
                         1'b0, '0);
                    tick_run($urandom_range(0, 9) < 7);
                end
                else if (pick < 72)
                begin
                    delta = $urandom_range(0, 12);
                    if ($urandom_range(0, 1))
                        delta = -delta;
                    lo = cfg_freq / 4 + 1;
                    if (lo > 65535)
                        lo = 65535;
                    prec = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(lo, 65535));
                    send(make_req(sspg_pkg::OP_PAUSE, delta, prec), 1'b0, '0);
                    tick_run($urandom_range(0, 9) < 7);
                end
                else if (pick < 85)
                    send(make_req(sspg_pkg::op_t'($urandom_range(0, 3)), $urandom,
                                  16'($urandom_range(0, 65535))), 1'b0, '0);
                else
                    repeat ($urandom_range(1, 5)) send_tick();
            end
        end

        drain();
        steady_flow = 1'b0;
        repeat (10) @(posedge clk);

        $display("covered %0d requests over %0d register settings", requests_sent,
                 PHASE_COUNT + 1);
        $display("model saw %0d step pulses, %0d pauses and %0d completions", pulse_total,
                 pause_total, done_total);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
sv/sspg_pkg.sv
sv/sspg_ctrl.sv
sv/sspg_datapath.sv
sv/stepper_step_pulse_generator_unit.sv
sv/sspg_checker.sv
tb/tb_stepper_step_pulse_generator_unit.sv
